### hdl/dpq_pkg.sv
`default_nettype none

package dpq_pkg;

  localparam int unsigned DEF_CAPACITY = 64;

  localparam int unsigned PID_W    = 31;
  localparam int unsigned DL_W     = 31;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 7;

  localparam int unsigned IN_DATA_W  = 64;  // pid, deadline, zero pad
  localparam int unsigned OUT_DATA_W = 72;  // status, min valid, pid, deadline, occupancy

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NO_MATCH = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_SCAN,
    S_COMMIT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load_item;
    logic cmp;
    logic scan;
    logic commit;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_delete;
  } dp_stat_t;

endpackage

`default_nettype wire

### hdl/deadline_priority_queue.sv
// Channel | Dir | Payload (low bit first)                                         | Notes
// s_axis  | in  | tuser: opcode; tdata: proc_id, deadline, 2 pad bits             | one per command
// m_axis  | out | tdata: status, min_valid, min_proc_id, min_deadline, occupancy | one per command
//
// Steps: insert goes compare, commit; delete goes compare, prefix scan, commit;
// the next item is taken at commit.
// Reset: clears the state machine, result valid and count; cells are not cleared
// and are never read above the count.
// Stalls: one result register; while it waits the next item is still taken and
// held in the commit step until the result is taken.
`default_nettype none

module deadline_priority_queue #(
  parameter int unsigned CAPACITY = dpq_pkg::DEF_CAPACITY
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [dpq_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,  // proc_id, deadline, pad
  input  logic                              s_axis_tuser_i,  // opcode
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [dpq_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o   // status, min_valid,
                                                             // min_proc_id,
                                                             // min_deadline, occupancy
);
  import dpq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  logic [STATUS_W-1:0] out_status;
  logic                out_min_valid;
  logic [PID_W-1:0]    out_min_proc_id;
  logic [DL_W-1:0]     out_min_deadline;
  logic [OCC_W-1:0]    out_occupancy;

  dpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dpq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .in_opcode_i        (s_axis_tuser_i),
    .in_proc_id_i       (s_axis_tdata_i[PID_W-1:0]),
    .in_deadline_i      (s_axis_tdata_i[PID_W+DL_W-1:PID_W]),
    .out_status_o       (out_status),
    .out_min_valid_o    (out_min_valid),
    .out_min_proc_id_o  (out_min_proc_id),
    .out_min_deadline_o (out_min_deadline),
    .out_occupancy_o    (out_occupancy)
  );

  // top bits of the input word are padding and ignored
  assign m_axis_tdata_o = {out_occupancy, out_min_deadline, out_min_proc_id,
                           out_min_valid, out_status};

endmodule

`default_nettype wire

### hdl/dpq_ctrl.sv
`default_nettype none

module dpq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_tvalid_i,
  output logic             s_tready_o,
  output logic             m_tvalid_o,
  input  logic             m_tready_i,
  input  dpq_pkg::dp_stat_t stat_i,
  output dpq_pkg::dp_cmd_t  cmd_o
);
  import dpq_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || m_tready_i;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_tready_o = 1'b1;
      end
      S_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d   = stat_i.is_delete ? S_SCAN : S_COMMIT;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        state_d    = S_COMMIT;
      end
      S_COMMIT: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          s_tready_o   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (s_tvalid_i && s_tready_o) begin
      cmd_o.load_item = 1'b1;
      state_d         = S_CMP;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end
  end

  assign m_tvalid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

### hdl/dpq_datapath.sv
`default_nettype none

module dpq_datapath #(
  parameter int unsigned CAPACITY = dpq_pkg::DEF_CAPACITY
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dpq_pkg::dp_cmd_t              cmd_i,
  output dpq_pkg::dp_stat_t             stat_o,
  input  logic                          in_opcode_i,
  input  logic [dpq_pkg::PID_W-1:0]     in_proc_id_i,
  input  logic [dpq_pkg::DL_W-1:0]      in_deadline_i,
  output logic [dpq_pkg::STATUS_W-1:0]  out_status_o,
  output logic                          out_min_valid_o,
  output logic [dpq_pkg::PID_W-1:0]     out_min_proc_id_o,
  output logic [dpq_pkg::DL_W-1:0]      out_min_deadline_o,
  output logic [dpq_pkg::OCC_W-1:0]     out_occupancy_o
);
  import dpq_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned BLK   = (CAPACITY < 32) ? CAPACITY : 32;
  localparam int unsigned NBLK  = (CAPACITY + BLK - 1) / BLK;
  localparam int unsigned PAD   = NBLK * BLK;

  // item register
  opcode_e          op_q;
  logic [PID_W-1:0] pid_q;
  logic [DL_W-1:0]  dl_q;

  // cell chain
  logic [PID_W-1:0] cell_pid_q [CAPACITY];
  logic [PID_W-1:0] cell_pid_d [CAPACITY];
  logic [DL_W-1:0]  cell_dl_q  [CAPACITY];
  logic [DL_W-1:0]  cell_dl_d  [CAPACITY];
  logic [CNT_W-1:0] count_q, count_d;

  // per-cell flags
  logic [CAPACITY-1:0] in_use;
  logic [CAPACITY-1:0] lt_d, lt_q;
  logic [CAPACITY-1:0] match_d, match_q;
  logic [PAD-1:0]      pre_in_d, pre_in_q;
  logic [NBLK-1:0]     blk_any_d, blk_any_q;
  logic [NBLK-1:0]     blk_excl;
  logic [CAPACITY-1:0] pre;
  logic                any_match;

  status_e status;
  logic    apply;

  assign stat_o.is_delete = (op_q == OP_DELETE);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q  <= opcode_e'(in_opcode_i);
      pid_q <= in_proc_id_i;
      dl_q  <= in_deadline_i;
    end
  end

  // compare stage: every cell against the held item
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cmp
    assign in_use[k]  = count_q > CNT_W'(k);
    assign lt_d[k]    = in_use[k] && (cell_dl_q[k] < dl_q);
    assign match_d[k] = in_use[k] && (cell_pid_q[k] == pid_q) && (cell_dl_q[k] == dl_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp) begin
      lt_q    <= lt_d;
      match_q <= match_d;
    end
  end

  // scan stage: in-block prefix OR of match flags, log-step
  always_comb begin
    logic [PAD-1:0] mpad;
    logic [BLK-1:0] v;
    mpad = PAD'(match_q);
    for (int b = 0; b < NBLK; b++) begin
      v = mpad[b*BLK +: BLK];
      blk_any_d[b] = |v;
      for (int s = 1; s < BLK; s = s * 2) begin
        v = v | (v << s);
      end
      pre_in_d[b*BLK +: BLK] = v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      pre_in_q  <= pre_in_d;
      blk_any_q <= blk_any_d;
    end
  end

  // cross-block prefix, exclusive
  always_comb begin
    logic [NBLK-1:0] w;
    w = blk_any_q;
    for (int s = 1; s < NBLK; s = s * 2) begin
      w = w | (w << s);
    end
    blk_excl = w << 1;
  end

  assign any_match = |blk_any_q;

  always_comb begin
    if (op_q == OP_INSERT) begin
      status = (count_q == CNT_W'(CAPACITY)) ? ST_FULL : ST_OK;
    end else begin
      status = any_match ? ST_OK : ST_NO_MATCH;
    end
  end

  assign apply = cmd_i.commit && (status == ST_OK);

  // cell next values: insert opens a gap at the first cell not below the key,
  // delete closes the gap at the first match
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic at_pos;
    logic [PID_W-1:0] up_pid;
    logic [DL_W-1:0]  up_dl;
    logic [PID_W-1:0] dn_pid;
    logic [DL_W-1:0]  dn_dl;

    assign pre[k] = pre_in_q[k] | blk_excl[k / BLK];

    if (k == 0) begin : g_head
      assign at_pos = !lt_q[k];
      assign up_pid = pid_q;
      assign up_dl  = dl_q;
    end else begin : g_body
      assign at_pos = !lt_q[k] && lt_q[k-1];
      assign up_pid = cell_pid_q[k-1];
      assign up_dl  = cell_dl_q[k-1];
    end

    if (k == CAPACITY - 1) begin : g_tail
      assign dn_pid = cell_pid_q[k];
      assign dn_dl  = cell_dl_q[k];
    end else begin : g_mid
      assign dn_pid = cell_pid_q[k+1];
      assign dn_dl  = cell_dl_q[k+1];
    end

    always_comb begin
      cell_pid_d[k] = cell_pid_q[k];
      cell_dl_d[k]  = cell_dl_q[k];
      if (apply) begin
        if (op_q == OP_INSERT) begin
          if (at_pos) begin
            cell_pid_d[k] = pid_q;
            cell_dl_d[k]  = dl_q;
          end else if (!lt_q[k]) begin
            cell_pid_d[k] = up_pid;
            cell_dl_d[k]  = up_dl;
          end
        end else if (pre[k]) begin
          cell_pid_d[k] = dn_pid;
          cell_dl_d[k]  = dn_dl;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cell_pid_q <= cell_pid_d;
    cell_dl_q  <= cell_dl_d;
  end

  always_comb begin
    count_d = count_q;
    if (apply) begin
      count_d = (op_q == OP_INSERT) ? count_q + 1'b1 : count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // result register, loaded with the post-update head
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_status_o       <= status;
      out_min_valid_o    <= (count_d != '0);
      out_min_proc_id_o  <= (count_d != '0) ? cell_pid_d[0] : '0;
      out_min_deadline_o <= (count_d != '0) ? cell_dl_d[0] : '0;
      out_occupancy_o    <= OCC_W'(count_d);
    end
  end

endmodule

`default_nettype wire

### hdl/dpq_checker.sv
`default_nettype none

module dpq_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [dpq_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);
  import dpq_pkg::*;

  logic [STATUS_W-1:0] st;
  logic                mv;
  logic [PID_W-1:0]    mpid;
  logic [DL_W-1:0]     mdl;
  logic [OCC_W-1:0]    occ;

  assign st   = m_axis_tdata_o[1:0];
  assign mv   = m_axis_tdata_o[2];
  assign mpid = m_axis_tdata_o[33:3];
  assign mdl  = m_axis_tdata_o[64:34];
  assign occ  = m_axis_tdata_o[71:65];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  a_min_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (mv == (occ != '0)))
    else $error("min valid disagrees with occupancy");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !mv |-> (mpid == '0) && (mdl == '0))
    else $error("empty table shows a head entry");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (st == ST_OK) || (st == ST_FULL) || (st == ST_NO_MATCH))
    else $error("undefined status code");

endmodule

bind deadline_priority_queue dpq_checker u_dpq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire

### tb/sv/tb_deadline_priority_queue.sv
`timescale 1ns / 100ps

module tb_deadline_priority_queue;
  import dpq_pkg::*;

  localparam int CAP      = DEF_CAPACITY;
  localparam int N_RANDOM = 1800;

  // one result item as it appears on m_axis
  typedef struct packed {
    status_e     status;
    logic        min_valid;
    logic [30:0] min_pid;
    logic [30:0] min_dl;
    logic [6:0]  occ;
  } dpq_res_t;

  // directed row; typed = 1 means the expected item is written out here
  typedef struct packed {
    opcode_e     op;
    logic [30:0] pid;
    logic [30:0] dl;
    logic        typed;
    dpq_res_t    res;
  } dir_row_t;

  typedef enum int {
    MIX_FILL,
    MIX_CHURN,
    MIX_DRAIN
  } mix_e;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i  = '0;  // proc_id, deadline, pad
  logic                  s_axis_tuser_i  = 1'b0;  // opcode
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;  // status, min_valid, min_proc_id,
                                          // min_deadline, occupancy

  // shadow of the sorted table, updated as items are taken
  logic [30:0] tbl_pid [CAP];
  logic [30:0] tbl_dl  [CAP];
  int          tbl_count = 0;

  dpq_res_t expected_results[$];
  int       pending     = 0;
  int       err_count   = 0;

  // idling control shared by both sides
  logic calm         = 1'b0;
  logic rx_hold_req  = 1'b0;
  logic rx_hold_done = 1'b0;
  int   rx_stall     = 0;
  int   rx_roll;

  // Directed part: empty-table delete, extremes, equal deadlines landing in
  // front, duplicate entries removed head first, pid-only and deadline-only
  // mismatches, then a short fill and drain back to empty.
  dir_row_t dir_rows [20] = '{
    '{OP_DELETE, 31'd0, 31'd0, 1'b1, '{ST_NO_MATCH, 1'b0, 31'd0, 31'd0, 7'd0}},
    '{OP_INSERT, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1,
      '{ST_OK, 1'b1, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 7'd1}},
    '{OP_INSERT, 31'd0, 31'd0, 1'b1, '{ST_OK, 1'b1, 31'd0, 31'd0, 7'd2}},
    '{OP_INSERT, 31'd5, 31'd0, 1'b1, '{ST_OK, 1'b1, 31'd5, 31'd0, 7'd3}},
    '{OP_INSERT, 31'd5, 31'd0, 1'b1, '{ST_OK, 1'b1, 31'd5, 31'd0, 7'd4}},
    '{OP_DELETE, 31'd5, 31'd0, 1'b1, '{ST_OK, 1'b1, 31'd5, 31'd0, 7'd3}},
    '{OP_DELETE, 31'd5, 31'd0, 1'b1, '{ST_OK, 1'b1, 31'd0, 31'd0, 7'd2}},
    '{OP_DELETE, 31'd0, 31'd1, 1'b1, '{ST_NO_MATCH, 1'b1, 31'd0, 31'd0, 7'd2}},
    '{OP_DELETE, 31'd1, 31'd0, 1'b1, '{ST_NO_MATCH, 1'b1, 31'd0, 31'd0, 7'd2}},
    '{OP_INSERT, 31'h2AAA_AAAA, 31'h5555_5555, 1'b0, '0},
    '{OP_INSERT, 31'h5555_5555, 31'h2AAA_AAAA, 1'b0, '0},
    '{OP_INSERT, 31'd3, 31'h7FFF_FFFE, 1'b0, '0},
    '{OP_INSERT, 31'd4, 31'd1, 1'b0, '0},
    '{OP_DELETE, 31'd0, 31'd0, 1'b0, '0},
    '{OP_DELETE, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0, '0},
    '{OP_DELETE, 31'h2AAA_AAAA, 31'h5555_5555, 1'b0, '0},
    '{OP_DELETE, 31'h5555_5555, 31'h2AAA_AAAA, 1'b0, '0},
    '{OP_DELETE, 31'd3, 31'h7FFF_FFFE, 1'b0, '0},
    '{OP_DELETE, 31'd4, 31'd1, 1'b1, '{ST_OK, 1'b0, 31'd0, 31'd0, 7'd0}},
    '{OP_DELETE, 31'd4, 31'd1, 1'b1, '{ST_NO_MATCH, 1'b0, 31'd0, 31'd0, 7'd0}}
  };

  deadline_priority_queue #(
    .CAPACITY(CAP)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always #5 clk_i = ~clk_i;

  // Sorted-table update for one item; returns the result it should produce.
  function automatic dpq_res_t table_step(opcode_e op, logic [30:0] pid, logic [30:0] dl);
    dpq_res_t r;
    int       pos;
    r        = '0;
    r.status = ST_OK;
    pos      = 0;
    if (op == OP_INSERT) begin
      if (tbl_count >= CAP) begin
        r.status = ST_FULL;
      end else begin
        // strict compare: new entry goes ahead of equal deadlines
        while (pos < tbl_count && tbl_dl[pos] < dl) pos++;
        for (int k = tbl_count; k > pos; k--) begin
          tbl_pid[k] = tbl_pid[k-1];
          tbl_dl[k]  = tbl_dl[k-1];
        end
        tbl_pid[pos] = pid;
        tbl_dl[pos]  = dl;
        tbl_count++;
      end
    end else begin
      while (pos < tbl_count && !(tbl_pid[pos] == pid && tbl_dl[pos] == dl)) pos++;
      if (pos >= tbl_count) begin
        r.status = ST_NO_MATCH;
      end else begin
        for (int k = pos; k + 1 < tbl_count; k++) begin
          tbl_pid[k] = tbl_pid[k+1];
          tbl_dl[k]  = tbl_dl[k+1];
        end
        tbl_count--;
      end
    end
    if (tbl_count > 0) begin
      r.min_valid = 1'b1;
      r.min_pid   = tbl_pid[0];
      r.min_dl    = tbl_dl[0];
    end
    r.occ = 7'(tbl_count);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random item, biased towards real entries so deletes mostly hit.
  task automatic pick_item(input mix_e mix, output opcode_e op,
                           output logic [30:0] pid, output logic [30:0] dl);
    int r;
    int idx;
    int ins_pct;
    ins_pct = (mix == MIX_FILL) ? 85 : (mix == MIX_DRAIN) ? 15 : 50;
    op  = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_DELETE;
    pid = ($urandom_range(0, 4) == 0) ? 31'($urandom_range(0, 3)) : 31'($urandom);
    r   = $urandom_range(0, 99);
    if (r < 40)      dl = 31'($urandom_range(0, 7));  // crowd equal deadlines
    else if (r < 50) dl = $urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'd0;
    else             dl = 31'($urandom);
    if (tbl_count > 0) begin
      r = $urandom_range(0, 9);
      if (r == 0)      idx = 0;
      else if (r == 1) idx = tbl_count - 1;
      else             idx = $urandom_range(0, tbl_count - 1);
      if (op == OP_DELETE) begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          pid = tbl_pid[idx];
          dl  = tbl_dl[idx];
        end else if (r < 90) begin
          pid = tbl_pid[idx];
          dl  = tbl_dl[idx] + 31'd1;
        end else if (r < 95) begin
          pid = tbl_pid[idx] ^ 31'd1;
          dl  = tbl_dl[idx];
        end
      end else if ($urandom_range(0, 9) == 0) begin
        pid = tbl_pid[idx];  // exact duplicate entry
        dl  = tbl_dl[idx];
      end
    end
  endtask

  // Offer one item and wait for it to be taken. Valid stays high across
  // back-to-back items; it is lowered only for a gap or while all results are awaited.
  task automatic offer_item(input opcode_e op, input logic [30:0] pid, input logic [30:0] dl,
                            input logic typed, input dpq_res_t typed_res);
    int       gap;
    dpq_res_t res;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= {2'b00, dl, pid};
    do @(posedge clk_i); while (!s_axis_tready_o);
    res = table_step(op, pid, dl);
    expected_results.push_back(typed ? typed_res : res);
    pending++;
  endtask

  task automatic wait_all_results();
    s_axis_tvalid_i <= 1'b0;
    wait (pending == 0);
    @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    err_count++;
  endtask

  // Result side: random back-pressure, plus one long hold-off on request so
  // the single result register and the held item back up into s_axis.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      rx_stall        <= 0;
    end else if (rx_hold_req && !rx_hold_done) begin
      rx_hold_done    <= 1'b1;
      rx_stall        <= 400;
      m_axis_tready_i <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall        <= rx_stall - 1;
      m_axis_tready_i <= 1'b0;
    end else if (calm) begin
      m_axis_tready_i <= 1'b1;
    end else begin
      rx_roll = $urandom_range(0, 99);
      if (rx_roll < 65) begin
        m_axis_tready_i <= 1'b1;
      end else begin
        m_axis_tready_i <= 1'b0;
        rx_stall        <= (rx_roll < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
      end
    end
  end

  // Checker: fields of m_axis tdata from the lowest bit up.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result item with nothing expected");
      end else begin
        automatic dpq_res_t want = expected_results.pop_front();
        pending--;
        if (m_axis_tdata_o[1:0] != want.status)
          report_mismatch($sformatf("status got %0d want %0d",
                                    m_axis_tdata_o[1:0], want.status));
        if (m_axis_tdata_o[2] != want.min_valid)
          report_mismatch($sformatf("min_valid got %0b want %0b",
                                    m_axis_tdata_o[2], want.min_valid));
        if (m_axis_tdata_o[33:3] != want.min_pid)
          report_mismatch($sformatf("min_proc_id got %h want %h",
                                    m_axis_tdata_o[33:3], want.min_pid));
        if (m_axis_tdata_o[64:34] != want.min_dl)
          report_mismatch($sformatf("min_deadline got %h want %h",
                                    m_axis_tdata_o[64:34], want.min_dl));
        if (m_axis_tdata_o[71:65] != want.occ)
          report_mismatch($sformatf("occupancy got %0d want %0d",
                                    m_axis_tdata_o[71:65], want.occ));
      end
    end
  end

  initial begin
    #(5_000_000);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    opcode_e     op;
    logic [30:0] pid;
    logic [30:0] dl;
    int          sent;
    int          phase;
    int          len;
    sent  = 0;
    phase = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      offer_item(dir_rows[i].op, dir_rows[i].pid, dir_rows[i].dl,
                 dir_rows[i].typed, dir_rows[i].res);
    wait_all_results();

    // fill / churn / drain in turn; fill runs long enough to hit a full table
    while (sent < N_RANDOM) begin
      calm = ($urandom_range(0, 4) == 0);
      if (phase == 1) rx_hold_req = 1'b1;
      len = $urandom_range(100, 160);
      for (int i = 0; i < len; i++) begin
        pick_item(mix_e'(phase % 3), op, pid, dl);
        offer_item(op, pid, dl, 1'b0, '0);
        sent++;
      end
      if (phase == 3 || $urandom_range(0, 3) == 0) wait_all_results();
      phase++;
    end

    wait_all_results();
    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### deadline_priority_queue.f
hdl/dpq_pkg.sv
hdl/dpq_ctrl.sv
hdl/dpq_datapath.sv
hdl/deadline_priority_queue.sv
hdl/dpq_checker.sv
tb/sv/tb_deadline_priority_queue.sv
